[hdl/bpcr_pkg.sv]
// Package for the ball pair collision response block.
// Holds shared widths, pipeline depths, register indexes, outcome codes and
// fixed point helper functions. Depends on nothing.
package bpcr_pkg;

    localparam int DIV_STEPS = 48;             // quotient bits of (|offset| << 16) / distance
    localparam int DIV_LAT   = DIV_STEPS + 1;  // load register plus one register per bit
    localparam int POST_LAT  = 9;              // stages after the divider
    localparam int NSTAGE    = DIV_LAT + POST_LAT;

    localparam logic [17:0] K_PUSH  = 18'd131727;       // 2.01 in Q16.16
    localparam logic [31:0] RECIP9  = 32'd3817748707;   // floor(2^35 / 9)
    localparam int          RECIP9_SHIFT = 35;

    localparam logic [1:0] REG_RESTITUTION = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_BOOST_SCALE = 2'd2;
    localparam logic [1:0] REG_BALL_RADIUS = 2'd3;

    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_BOOST  = 2'd1;
    localparam logic [1:0] OUT_FORCED = 2'd2;
    localparam logic [1:0] OUT_ZERO   = 2'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Divides a product by 65536, truncating toward zero.
    function automatic logic signed [63:0] q_trunc(input logic signed [63:0] p);
        logic signed [63:0] biased;
        begin
            biased = p + (p[63] ? 64'sd65535 : 64'sd0);
            return biased >>> 16;
        end
    endfunction

    // Saturates to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
            begin
                return S32_MAX;
            end
            else if (v < -64'sd2147483648)
            begin
                return S32_MIN;
            end
            else
            begin
                return v[31:0];
            end
        end
    endfunction

endpackage

[hdl/bpcr_div.sv]
// Pipelined restoring divider pair for the unit normal of bpcr.
// One quotient bit per stage, both offsets share the divisor.
// Depends on bpcr_pkg.
module bpcr_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic [31:0]                        num_a,
    input  logic [31:0]                        num_b,
    input  logic [30:0]                        den,
    output logic [bpcr_pkg::DIV_STEPS-1:0]     quo_a,
    output logic [bpcr_pkg::DIV_STEPS-1:0]     quo_b
);

    localparam int W = bpcr_pkg::DIV_STEPS;

    logic [W-1:0]  na_reg  [0:W];
    logic [W-1:0]  nb_reg  [0:W];
    logic [30:0]   ra_reg  [0:W];
    logic [30:0]   rb_reg  [0:W];
    logic [30:0]   den_reg [0:W];

    // One restoring step: the numerator shifts out its top bit and the
    // quotient bit shifts in at the bottom.
    function automatic logic [W+30:0] div_step(input logic [30:0] rem,
                                               input logic [W-1:0] num,
                                               input logic [30:0] dv);
        logic [31:0] t;
        logic [31:0] diff;
        begin
            t    = {rem, num[W-1]};
            diff = t - {1'b0, dv};
            if (t >= {1'b0, dv})
            begin
                return {diff[30:0], num[W-2:0], 1'b1};
            end
            else
            begin
                return {t[30:0], num[W-2:0], 1'b0};
            end
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg[0]  <= {num_a, {(W-32){1'b0}}};
            nb_reg[0]  <= {num_b, {(W-32){1'b0}}};
            ra_reg[0]  <= '0;
            rb_reg[0]  <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W+30:0] sa_next;
        logic [W+30:0] sb_next;

        always_comb
        begin
            sa_next = div_step(ra_reg[k-1], na_reg[k-1], den_reg[k-1]);
            sb_next = div_step(rb_reg[k-1], nb_reg[k-1], den_reg[k-1]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[k]  <= sa_next[W+30:W];
                na_reg[k]  <= sa_next[W-1:0];
                rb_reg[k]  <= sb_next[W+30:W];
                nb_reg[k]  <= sb_next[W-1:0];
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo_a = na_reg[W];
    assign quo_b = nb_reg[W];

endmodule

[hdl/ball_pair_collision_response.sv]
// Ball pair collision response: a deep pipeline in Q16.16 fixed point.
// Path of an item: 49 divider registers (load plus one per quotient bit),
// eight arithmetic stages and the output register, the first loaded at the
// transfer edge. Throughput: one item per cycle; a held result stalls all.
// Reset (rst_n, async, active low) empties the pipeline and loads the defaults.
module ball_pair_collision_response (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_vx,
    input  logic signed [31:0] first_vy,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_vx,
    input  logic signed [31:0] second_vy,
    input  logic [30:0]        center_distance,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_first_vx,
    output logic signed [31:0] new_first_vy,
    output logic signed [31:0] new_second_vx,
    output logic signed [31:0] new_second_vy,
    output logic signed [31:0] new_second_x,
    output logic signed [31:0] new_second_y,
    output logic [1:0]         outcome
);

    // The input fields of one item, carried alongside the arithmetic.
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic [30:0]        d;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } pay_t;

    // Stage 1: saturated unit normal and tangent.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } s1_t;

    // Stage 2: products for the normal and tangent dot products.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [63:0] pn1a;
        logic signed [63:0] pn1b;
        logic signed [63:0] pt1a;
        logic signed [63:0] pt1b;
        logic signed [63:0] pn2a;
        logic signed [63:0] pn2b;
        logic signed [63:0] pt2a;
        logic signed [63:0] pt2b;
    } s2_t;

    // Stage 3: saturated dot products.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] nd1;
        logic signed [31:0] td1;
        logic signed [31:0] nd2;
        logic signed [31:0] td2;
    } s3_t;

    // Stage 4: products that rebuild the normal and tangent vectors.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [63:0] m1nx;
        logic signed [63:0] m1ny;
        logic signed [63:0] m1tx;
        logic signed [63:0] m1ty;
        logic signed [63:0] m2nx;
        logic signed [63:0] m2ny;
        logic signed [63:0] m2tx;
        logic signed [63:0] m2ty;
    } s4_t;

    // Stage 5: normal and tangent components of both velocities.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] n1x;
        logic signed [31:0] n1y;
        logic signed [31:0] t1x;
        logic signed [31:0] t1y;
        logic signed [31:0] n2x;
        logic signed [31:0] n2y;
        logic signed [31:0] t2x;
        logic signed [31:0] t2y;
    } s5_t;

    // Stage 6: approach test products and restitution products.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [63:0] dn1a;
        logic signed [63:0] dn1b;
        logic signed [63:0] dn2a;
        logic signed [63:0] dn2b;
        logic signed [63:0] en2x;
        logic signed [63:0] en2y;
        logic signed [63:0] en1x;
        logic signed [63:0] en1y;
        logic signed [31:0] t1x;
        logic signed [31:0] t1y;
        logic signed [31:0] t2x;
        logic signed [31:0] t2y;
        logic               cmp1;
        logic               cmp2;
    } s6_t;

    // Stage 7: collision decision, exchanged velocities, overlap boost.
    typedef struct packed {
        pay_t               p;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic               coll;
        logic signed [31:0] r1x;
        logic signed [31:0] r1y;
        logic signed [31:0] r2x;
        logic signed [31:0] r2y;
        logic [30:0]        add;
    } s7_t;

    // Stage 8: speed test and the boost and push products.
    typedef struct packed {
        pay_t               p;
        logic               coll;
        logic               forced;
        logic signed [31:0] r1x;
        logic signed [31:0] r1y;
        logic signed [31:0] r2x;
        logic signed [31:0] r2y;
        logic signed [63:0] padd_x;
        logic signed [63:0] padd_y;
        logic signed [63:0] ppush_x;
        logic signed [63:0] ppush_y;
    } s8_t;

    // Output register.
    typedef struct packed {
        logic signed [31:0] vx1;
        logic signed [31:0] vy1;
        logic signed [31:0] vx2;
        logic signed [31:0] vy2;
        logic signed [31:0] px2;
        logic signed [31:0] py2;
        logic [1:0]         oc;
    } out_t;

    localparam int LAST = bpcr_pkg::NSTAGE - 1;

    // ------------------------------------------------------------------
    // Configuration registers and derived values. The user must let writes
    // arrive only while the pipeline is empty, which the block does not enforce;
    // then derived values settle long before an item reaches the stage using them.
    // ------------------------------------------------------------------
    logic [15:0] restitution_reg;
    logic [30:0] max_speed_reg;
    logic [30:0] boost_scale_reg;
    logic [30:0] ball_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= 16'd58982;
            max_speed_reg   <= 31'd131072;
            boost_scale_reg <= 31'd524288;
            ball_radius_reg <= 31'd655360;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpcr_pkg::REG_RESTITUTION: restitution_reg <= cfg_data[15:0];
                bpcr_pkg::REG_MAX_SPEED:   max_speed_reg   <= cfg_data[30:0];
                bpcr_pkg::REG_BOOST_SCALE: boost_scale_reg <= cfg_data[30:0];
                bpcr_pkg::REG_BALL_RADIUS: ball_radius_reg <= cfg_data[30:0];
                default:                   ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Push distance 2.01 * radius, truncated and saturated to 31 bits.
    // The scale / 9 is a reciprocal multiply that can land one low, fixed
    // up with one compare against the remainder.
    logic [48:0] push_prod;
    logic [30:0] push_next;
    logic [30:0] push_reg;
    logic [62:0] prod9_reg;
    logic [30:0] scale_d_reg;
    logic [27:0] q9_est;
    logic [30:0] q9_rem;
    logic [27:0] scale9_next;
    logic [27:0] scale9_reg;

    always_comb
    begin
        push_prod   = 49'(bpcr_pkg::K_PUSH) * 49'(ball_radius_reg);
        push_next   = (push_prod[48:47] != 2'b00) ? 31'h7FFF_FFFF : push_prod[46:16];
        q9_est      = prod9_reg[bpcr_pkg::RECIP9_SHIFT +: 28];
        q9_rem      = scale_d_reg - (31'(q9_est) * 31'd9);
        scale9_next = (q9_rem >= 31'd9) ? q9_est + 28'd1 : q9_est;
    end

    always_ff @(posedge clk)
    begin
        push_reg    <= push_next;
        prod9_reg   <= 63'(boost_scale_reg) * 63'(bpcr_pkg::RECIP9);
        scale_d_reg <= boost_scale_reg;
        scale9_reg  <= scale9_next;
    end

    // ------------------------------------------------------------------
    // Flow control: every stage advances together unless the result in the
    // output register is held by the consumer.
    // ------------------------------------------------------------------
    logic vld_reg [0:LAST];
    logic en;

    assign en       = !(vld_reg[LAST] && !out_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: |offset| * 65536 / distance for both axes. The fields of the
    // item ride a delay line of the same depth.
    // ------------------------------------------------------------------
    pay_t pay_in;
    pay_t pay_reg [0:bpcr_pkg::DIV_LAT-1];
    logic [31:0] abs_dx;
    logic [31:0] abs_dy;
    logic [bpcr_pkg::DIV_STEPS-1:0] quo_x;
    logic [bpcr_pkg::DIV_STEPS-1:0] quo_y;

    always_comb
    begin
        pay_in.x1  = first_x;
        pay_in.y1  = first_y;
        pay_in.v1x = first_vx;
        pay_in.v1y = first_vy;
        pay_in.x2  = second_x;
        pay_in.y2  = second_y;
        pay_in.v2x = second_vx;
        pay_in.v2y = second_vy;
        pay_in.d   = center_distance;
        pay_in.dx  = offset_x;
        pay_in.dy  = offset_y;
        abs_dx     = offset_x[31] ? 32'(-offset_x) : 32'(offset_x);
        abs_dy     = offset_y[31] ? 32'(-offset_y) : 32'(offset_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= pay_in;
            for (int i = 1; i < bpcr_pkg::DIV_LAT; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    bpcr_div u_div (
        .clk   (clk),
        .en    (en),
        .num_a (abs_dx),
        .num_b (abs_dy),
        .den   (center_distance),
        .quo_a (quo_x),
        .quo_b (quo_y)
    );

    // Applies the offset's sign to a quotient and saturates to 32 bits.
    function automatic logic signed [31:0] sign_sat(
        input logic [bpcr_pkg::DIV_STEPS-1:0] q, input logic neg);
        begin
            if (!neg)
            begin
                return (q > bpcr_pkg::DIV_STEPS'(32'h7FFF_FFFF)) ?
                       bpcr_pkg::S32_MAX : $signed(q[31:0]);
            end
            else
            begin
                return (q >= bpcr_pkg::DIV_STEPS'(32'h8000_0000)) ?
                       bpcr_pkg::S32_MIN : $signed(-q[31:0]);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Arithmetic stages after the divider.
    // ------------------------------------------------------------------
    s1_t  s1_next, s1_reg;
    s2_t  s2_next, s2_reg;
    s3_t  s3_next, s3_reg;
    s4_t  s4_next, s4_reg;
    s5_t  s5_next, s5_reg;
    s6_t  s6_next, s6_reg;
    s7_t  s7_next, s7_reg;
    s8_t  s8_next, s8_reg;
    out_t out_next, out_reg;

    logic signed [64:0] dot1;
    logic signed [64:0] dot2;
    logic               f1;
    logic               f2;
    logic signed [31:0] ms;
    logic [32:0]        three_r;

    always_comb
    begin
        // Stage 1: unit normal; the tangent is the normal turned a quarter turn.
        s1_next.p  = pay_reg[bpcr_pkg::DIV_LAT-1];
        s1_next.ux = sign_sat(quo_x, pay_reg[bpcr_pkg::DIV_LAT-1].dx[31]);
        s1_next.uy = sign_sat(quo_y, pay_reg[bpcr_pkg::DIV_LAT-1].dy[31]);
        s1_next.ax = s1_next.uy;
        s1_next.ay = (s1_next.ux == bpcr_pkg::S32_MIN) ? bpcr_pkg::S32_MAX : -s1_next.ux;

        // Stage 2: dot product terms of each velocity with normal and tangent.
        s2_next.p    = s1_reg.p;
        s2_next.ux   = s1_reg.ux;
        s2_next.uy   = s1_reg.uy;
        s2_next.ax   = s1_reg.ax;
        s2_next.ay   = s1_reg.ay;
        s2_next.pn1a = 64'(s1_reg.p.v1x) * 64'(s1_reg.ux);
        s2_next.pn1b = 64'(s1_reg.p.v1y) * 64'(s1_reg.uy);
        s2_next.pt1a = 64'(s1_reg.p.v1x) * 64'(s1_reg.ax);
        s2_next.pt1b = 64'(s1_reg.p.v1y) * 64'(s1_reg.ay);
        s2_next.pn2a = 64'(s1_reg.p.v2x) * 64'(s1_reg.ux);
        s2_next.pn2b = 64'(s1_reg.p.v2y) * 64'(s1_reg.uy);
        s2_next.pt2a = 64'(s1_reg.p.v2x) * 64'(s1_reg.ax);
        s2_next.pt2b = 64'(s1_reg.p.v2y) * 64'(s1_reg.ay);

        // Stage 3: each term is scaled back separately, then summed.
        s3_next.p   = s2_reg.p;
        s3_next.ux  = s2_reg.ux;
        s3_next.uy  = s2_reg.uy;
        s3_next.ax  = s2_reg.ax;
        s3_next.ay  = s2_reg.ay;
        s3_next.nd1 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s2_reg.pn1a)
                                      + bpcr_pkg::q_trunc(s2_reg.pn1b));
        s3_next.td1 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s2_reg.pt1a)
                                      + bpcr_pkg::q_trunc(s2_reg.pt1b));
        s3_next.nd2 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s2_reg.pn2a)
                                      + bpcr_pkg::q_trunc(s2_reg.pn2b));
        s3_next.td2 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s2_reg.pt2a)
                                      + bpcr_pkg::q_trunc(s2_reg.pt2b));

        // Stage 4: project the dot products back onto the axes.
        s4_next.p    = s3_reg.p;
        s4_next.ux   = s3_reg.ux;
        s4_next.uy   = s3_reg.uy;
        s4_next.m1nx = 64'(s3_reg.ux) * 64'(s3_reg.nd1);
        s4_next.m1ny = 64'(s3_reg.uy) * 64'(s3_reg.nd1);
        s4_next.m1tx = 64'(s3_reg.ax) * 64'(s3_reg.td1);
        s4_next.m1ty = 64'(s3_reg.ay) * 64'(s3_reg.td1);
        s4_next.m2nx = 64'(s3_reg.ux) * 64'(s3_reg.nd2);
        s4_next.m2ny = 64'(s3_reg.uy) * 64'(s3_reg.nd2);
        s4_next.m2tx = 64'(s3_reg.ax) * 64'(s3_reg.td2);
        s4_next.m2ty = 64'(s3_reg.ay) * 64'(s3_reg.td2);

        // Stage 5: normal and tangent components.
        s5_next.p   = s4_reg.p;
        s5_next.ux  = s4_reg.ux;
        s5_next.uy  = s4_reg.uy;
        s5_next.n1x = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m1nx));
        s5_next.n1y = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m1ny));
        s5_next.t1x = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m1tx));
        s5_next.t1y = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m1ty));
        s5_next.n2x = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m2nx));
        s5_next.n2y = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m2ny));
        s5_next.t2x = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m2tx));
        s5_next.t2y = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s4_reg.m2ty));

        // Stage 6: exact approach products against the raw offset, and the
        // restitution products of the swapped normal parts.
        s6_next.p    = s5_reg.p;
        s6_next.ux   = s5_reg.ux;
        s6_next.uy   = s5_reg.uy;
        s6_next.dn1a = 64'(s5_reg.n1x) * 64'(s5_reg.p.dx);
        s6_next.dn1b = 64'(s5_reg.n1y) * 64'(s5_reg.p.dy);
        s6_next.dn2a = 64'(s5_reg.n2x) * 64'(s5_reg.p.dx);
        s6_next.dn2b = 64'(s5_reg.n2y) * 64'(s5_reg.p.dy);
        s6_next.en2x = 64'($signed({1'b0, restitution_reg})) * 64'(s5_reg.n2x);
        s6_next.en2y = 64'($signed({1'b0, restitution_reg})) * 64'(s5_reg.n2y);
        s6_next.en1x = 64'($signed({1'b0, restitution_reg})) * 64'(s5_reg.n1x);
        s6_next.en1y = 64'($signed({1'b0, restitution_reg})) * 64'(s5_reg.n1y);
        s6_next.t1x  = s5_reg.t1x;
        s6_next.t1y  = s5_reg.t1y;
        s6_next.t2x  = s5_reg.t2x;
        s6_next.t2y  = s5_reg.t2y;
        s6_next.cmp1 = (s5_reg.n1x > s5_reg.n2x) || (s5_reg.n1y > s5_reg.n2y);
        s6_next.cmp2 = (s5_reg.n2x > s5_reg.n1x) || (s5_reg.n2y > s5_reg.n1y);

        // Stage 7: ball one moving toward ball two (f1) or ball two moving
        // toward ball one (f2) decides the collision. The sums are one bit
        // wider so the sign stays exact.
        dot1 = 65'(s6_reg.dn1a) + 65'(s6_reg.dn1b);
        dot2 = 65'(s6_reg.dn2a) + 65'(s6_reg.dn2b);
        f1   = !dot1[64] && (dot1 != 65'sd0);
        f2   = dot2[64];

        s7_next.p    = s6_reg.p;
        s7_next.ux   = s6_reg.ux;
        s7_next.uy   = s6_reg.uy;
        s7_next.coll = (f1 && f2) || (f1 && s6_reg.cmp1) || (f2 && s6_reg.cmp2);
        s7_next.r1x  = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s6_reg.en2x) + 64'(s6_reg.t1x));
        s7_next.r1y  = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s6_reg.en2y) + 64'(s6_reg.t1y));
        s7_next.r2x  = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s6_reg.en1x) + 64'(s6_reg.t2x));
        s7_next.r2y  = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s6_reg.en1y) + 64'(s6_reg.t2y));

        // Overlap bands: beyond 1.5 r, beyond r, beyond 0.5 r, or deeper.
        three_r = {2'b00, ball_radius_reg} + {1'b0, ball_radius_reg, 1'b0};
        if ({1'b0, s6_reg.p.d, 1'b0} > three_r)
        begin
            s7_next.add = boost_scale_reg >> 4;
        end
        else if (s6_reg.p.d > ball_radius_reg)
        begin
            s7_next.add = 31'(scale9_reg);
        end
        else if ({s6_reg.p.d, 1'b0} > {1'b0, ball_radius_reg})
        begin
            s7_next.add = boost_scale_reg >> 2;
        end
        else
        begin
            s7_next.add = boost_scale_reg;
        end

        // Stage 8: speed limit test, boost and push products.
        ms = $signed({1'b0, max_speed_reg});
        s8_next.p       = s7_reg.p;
        s8_next.coll    = s7_reg.coll;
        s8_next.forced  = (s7_reg.r1x > ms) && (s7_reg.r1y > ms)
                          && (s7_reg.r2x > ms) && (s7_reg.r2y > ms);
        s8_next.r1x     = s7_reg.r1x;
        s8_next.r1y     = s7_reg.r1y;
        s8_next.r2x     = s7_reg.r2x;
        s8_next.r2y     = s7_reg.r2y;
        s8_next.padd_x  = 64'($signed({1'b0, s7_reg.add})) * 64'(s7_reg.ux);
        s8_next.padd_y  = 64'($signed({1'b0, s7_reg.add})) * 64'(s7_reg.uy);
        s8_next.ppush_x = 64'($signed({1'b0, push_reg})) * 64'(s7_reg.ux);
        s8_next.ppush_y = 64'($signed({1'b0, push_reg})) * 64'(s7_reg.uy);

        // Stage 9: pick the result. Zero distance and no collision pass the
        // inputs through; forced displacement moves ball two; otherwise ball
        // two's velocity gets the overlap boost.
        if (s8_reg.p.d == 31'd0)
        begin
            out_next.vx1 = s8_reg.p.v1x;
            out_next.vy1 = s8_reg.p.v1y;
            out_next.vx2 = s8_reg.p.v2x;
            out_next.vy2 = s8_reg.p.v2y;
            out_next.px2 = s8_reg.p.x2;
            out_next.py2 = s8_reg.p.y2;
            out_next.oc  = bpcr_pkg::OUT_ZERO;
        end
        else if (!s8_reg.coll)
        begin
            out_next.vx1 = s8_reg.p.v1x;
            out_next.vy1 = s8_reg.p.v1y;
            out_next.vx2 = s8_reg.p.v2x;
            out_next.vy2 = s8_reg.p.v2y;
            out_next.px2 = s8_reg.p.x2;
            out_next.py2 = s8_reg.p.y2;
            out_next.oc  = bpcr_pkg::OUT_NONE;
        end
        else if (s8_reg.forced)
        begin
            out_next.vx1 = s8_reg.r1x;
            out_next.vy1 = s8_reg.r1y;
            out_next.vx2 = s8_reg.r2x;
            out_next.vy2 = s8_reg.r2y;
            out_next.px2 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s8_reg.ppush_x)
                                           + 64'(s8_reg.p.x1));
            out_next.py2 = bpcr_pkg::sat32(bpcr_pkg::q_trunc(s8_reg.ppush_y)
                                           + 64'(s8_reg.p.y1));
            out_next.oc  = bpcr_pkg::OUT_FORCED;
        end
        else
        begin
            out_next.vx1 = s8_reg.r1x;
            out_next.vy1 = s8_reg.r1y;
            out_next.vx2 = bpcr_pkg::sat32(64'(s8_reg.r2x)
                                           + bpcr_pkg::q_trunc(s8_reg.padd_x));
            out_next.vy2 = bpcr_pkg::sat32(64'(s8_reg.r2y)
                                           + bpcr_pkg::q_trunc(s8_reg.padd_y));
            out_next.px2 = s8_reg.p.x2;
            out_next.py2 = s8_reg.p.y2;
            out_next.oc  = bpcr_pkg::OUT_BOOST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            out_reg <= out_next;
        end
    end

    assign out_valid     = vld_reg[LAST];
    assign new_first_vx  = out_reg.vx1;
    assign new_first_vy  = out_reg.vy1;
    assign new_second_vx = out_reg.vx2;
    assign new_second_vy = out_reg.vy2;
    assign new_second_x  = out_reg.px2;
    assign new_second_y  = out_reg.py2;
    assign outcome       = out_reg.oc;

endmodule

[hdl/bpcr_checker.sv]
// Port level checks for ball_pair_collision_response, attached by bind.
// Watches the handshakes and the held result. Depends on the top level only.
module bpcr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_ready,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] new_second_vx,
    input logic signed [31:0] new_second_x,
    input logic [1:0]         outcome
);

    // With no result waiting, the block must take new items.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output empty");

    // A held result stalls the input side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while result stalled");

    // A held result stays put.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome)
            && $stable(new_second_vx) && $stable(new_second_x))
        else $error("stalled result changed");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind ball_pair_collision_response bpcr_checker u_bpcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_second_vx (new_second_vx),
    .new_second_x  (new_second_x),
    .outcome       (outcome)
);

[test/tb_ball_pair_collision_response.sv]
// Testbench for the ball pair collision response pipeline.
// Drives random and directed ball pairs, predicts every result in Q16.16 and checks it.
// Depends on bpcr_pkg and ball_pair_collision_response.
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] x1, y1, v1x, v1y, x2, y2, v2x, v2y;
    logic [30:0]        cdist;
    logic signed [31:0] dx, dy;
} pair_t;

typedef struct {
    logic signed [31:0] r1x, r1y, r2x, r2y, p2x, p2y;
    logic [1:0]         oc;
} response_t;

// Holds the expected responses in order and checks the arriving ones.
class response_board;
    response_t pending[$];
    int errors;
    longint restitution, max_speed, boost_scale, ball_radius;

    function new();
        errors = 0;
        restitution = 58982;
        max_speed = 131072;
        boost_scale = 524288;
        ball_radius = 655360;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
        case (idx)
            bpcr_pkg::REG_RESTITUTION: restitution = longint'(val[15:0]);
            bpcr_pkg::REG_MAX_SPEED:   max_speed = longint'(val[30:0]);
            bpcr_pkg::REG_BOOST_SCALE: boost_scale = longint'(val[30:0]);
            bpcr_pkg::REG_BALL_RADIUS: ball_radius = longint'(val[30:0]);
            default:                   ;
        endcase
    endfunction

    static function longint clip(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    static function longint qmul(longint a, longint b);
        return (a * b) / 65536;
    endfunction

    // Splits a velocity into its parts along the normal and the tangent.
    static function void resolve(longint vx, longint vy, longint ux, longint uy,
                                 output longint nx, output longint ny,
                                 output longint tx, output longint ty);
        longint ax, ay, nd, td;
        ax = uy;
        ay = clip(-ux);
        nd = clip(qmul(vx, ux) + qmul(vy, uy));
        td = clip(qmul(vx, ax) + qmul(vy, ay));
        nx = clip(qmul(ux, nd));
        ny = clip(qmul(uy, nd));
        tx = clip(qmul(ax, td));
        ty = clip(qmul(ay, td));
    endfunction

    // Exact sign of a*c + b*d.
    static function int sign_of_dot(longint a, longint b, longint c, longint d);
        longint p, q;
        p = a * c;
        q = -(b * d);
        return (p > q) ? 1 : ((p < q) ? -1 : 0);
    endfunction

    function void note_pair(pair_t p);
        response_t r;
        longint d, ux, uy, n1x, n1y, t1x, t1y, n2x, n2y, t2x, t2y, push, add;
        bit f1, f2;
        r.r1x = p.v1x; r.r1y = p.v1y; r.r2x = p.v2x; r.r2y = p.v2y;
        r.p2x = p.x2; r.p2y = p.y2;
        r.oc = bpcr_pkg::OUT_NONE;
        d = longint'(p.cdist);
        if (d == 0)
        begin
            r.oc = bpcr_pkg::OUT_ZERO;
        end
        else
        begin
            ux = clip((longint'(p.dx) * 65536) / d);
            uy = clip((longint'(p.dy) * 65536) / d);
            resolve(p.v1x, p.v1y, ux, uy, n1x, n1y, t1x, t1y);
            resolve(p.v2x, p.v2y, ux, uy, n2x, n2y, t2x, t2y);
            f1 = sign_of_dot(n1x, n1y, p.dx, p.dy) > 0;
            f2 = sign_of_dot(n2x, n2y, p.dx, p.dy) < 0;
            if ((f1 && f2) || (f1 && (n1x > n2x || n1y > n2y))
                    || (f2 && (n2x > n1x || n2y > n1y)))
            begin
                longint a1x, a1y, a2x, a2y;
                a1x = clip((restitution * n2x) / 65536 + t1x);
                a1y = clip((restitution * n2y) / 65536 + t1y);
                a2x = clip((restitution * n1x) / 65536 + t2x);
                a2y = clip((restitution * n1y) / 65536 + t2y);
                if (a1x > max_speed && a1y > max_speed && a2x > max_speed
                        && a2y > max_speed)
                begin
                    push = clip((64'sd131727 * ball_radius) / 65536);
                    r.p2x = 32'(clip(qmul(push, ux) + p.x1));
                    r.p2y = 32'(clip(qmul(push, uy) + p.y1));
                    r.oc = bpcr_pkg::OUT_FORCED;
                end
                else
                begin
                    if (2 * d > 3 * ball_radius)
                        add = boost_scale / 16;
                    else if (d > ball_radius)
                        add = boost_scale / 9;
                    else if (2 * d > ball_radius)
                        add = boost_scale / 4;
                    else
                        add = boost_scale;
                    a2x = clip(a2x + qmul(add, ux));
                    a2y = clip(a2y + qmul(add, uy));
                    r.oc = bpcr_pkg::OUT_BOOST;
                end
                r.r1x = 32'(a1x); r.r1y = 32'(a1y); r.r2x = 32'(a2x); r.r2y = 32'(a2y);
            end
        end
        pending.push_back(r);
    endfunction

    task check_response(response_t got);
        response_t want;
        if (pending.size() == 0)
        begin
            report_field("response with nothing pending", 0, 0);
            return;
        end
        want = pending.pop_front();
        if (got.r1x !== want.r1x) report_field("new_first_vx", got.r1x, want.r1x);
        if (got.r1y !== want.r1y) report_field("new_first_vy", got.r1y, want.r1y);
        if (got.r2x !== want.r2x) report_field("new_second_vx", got.r2x, want.r2x);
        if (got.r2y !== want.r2y) report_field("new_second_vy", got.r2y, want.r2y);
        if (got.p2x !== want.p2x) report_field("new_second_x", got.p2x, want.p2x);
        if (got.p2y !== want.p2y) report_field("new_second_y", got.p2y, want.p2y);
        if (got.oc !== want.oc) report_field("outcome", got.oc, want.oc);
    endtask

    // Prints one line per mismatch and counts it.
    task report_field(string name, longint got, longint want);
        errors++;
        $display("ERROR: %s got %0d expected %0d", name, got, want);
    endtask
endclass

module tb_ball_pair_collision_response;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] first_x, first_y, first_vx, first_vy;
    logic signed [31:0] second_x, second_y, second_vx, second_vy;
    logic [30:0]        center_distance;
    logic signed [31:0] offset_x, offset_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_first_vx, new_first_vy, new_second_vx, new_second_vy;
    logic signed [31:0] new_second_x, new_second_y;
    logic [1:0]         outcome;

    response_board board;
    // The receiver holds off for a long stretch while this flag is set.
    bit  hold_receiver;
    int  idle_cycles;

    ball_pair_collision_response dut (.*);

    // 20 ns clock: 10 ns high, 10 ns low.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver: stalls on its own pattern, a run of ready cycles then a random
    // stall, unless a long hold-off is requested. Checks every result transfer.
    initial
    begin
        int run;
        out_ready = 1'b0;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_response('{new_first_vx, new_first_vy, new_second_vx,
                                       new_second_vy, new_second_x, new_second_y,
                                       outcome});
            if (hold_receiver)
                out_ready <= 1'b0;
            else if (run > 0)
            begin
                run--;
                out_ready <= 1'b1;
            end
            else
            begin
                // Stretches of full speed alternate with short stalls.
                out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : 0;
            end
        end
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Writes one register; valid drops for a cycle before the next write.
    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one pair and waits for its transfer; valid drops only when the
    // sender goes idle, so back to back items keep it high.
    task automatic send_pair(pair_t p);
        in_valid        <= 1'b1;
        first_x         <= p.x1;
        first_y         <= p.y1;
        first_vx        <= p.v1x;
        first_vy        <= p.v1y;
        second_x        <= p.x2;
        second_y        <= p.y2;
        second_vx       <= p.v2x;
        second_vy       <= p.v2y;
        center_distance <= p.cdist;
        offset_x        <= p.dx;
        offset_y        <= p.dy;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_pair(p);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every expected result has come, then lets the pipeline drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic signed [31:0] any_word();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom();
        endcase
    endfunction

    // Builds a pair: distance usually up to diameter + 200000, else far larger; an offset
    // consistent with it, with velocities that usually approach each other.
    function automatic pair_t touching_pair();
        pair_t p;
        int    ang;
        real   dr, c, s;
        dr = $urandom_range(1, 2 * 655360 + 200000);
        if ($urandom_range(0, 3) == 0)
            dr = $urandom_range(1, 2000000000);
        ang = $urandom_range(0, 359);
        c = $cos(ang * 3.14159265 / 180.0);
        s = $sin(ang * 3.14159265 / 180.0);
        p.cdist = 31'(int'(dr));
        p.dx   = int'(dr * c) + $signed($urandom_range(0, 4)) - 2;
        p.dy   = int'(dr * s) + $signed($urandom_range(0, 4)) - 2;
        p.x1   = $signed($urandom_range(0, 40000000)) - 20000000;
        p.y1   = $signed($urandom_range(0, 40000000)) - 20000000;
        p.x2   = p.x1 + p.dx;
        p.y2   = p.y1 + p.dy;
        p.v1x  = int'(c * $urandom_range(0, 2000000)) + $signed($urandom_range(0, 400000)) - 200000;
        p.v1y  = int'(s * $urandom_range(0, 2000000)) + $signed($urandom_range(0, 400000)) - 200000;
        p.v2x  = -int'(c * $urandom_range(0, 2000000)) + $signed($urandom_range(0, 400000)) - 200000;
        p.v2y  = -int'(s * $urandom_range(0, 2000000)) + $signed($urandom_range(0, 400000)) - 200000;
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        p.x1 = any_word(); p.y1 = any_word(); p.v1x = any_word(); p.v1y = any_word();
        p.x2 = any_word(); p.y2 = any_word(); p.v2x = any_word(); p.v2y = any_word();
        p.dx = any_word(); p.dy = any_word();
        case ($urandom_range(0, 4))
            0:       p.cdist = '0;
            1:       p.cdist = 31'h7FFF_FFFF;
            default: p.cdist = 31'($urandom());
        endcase
        return p;
    endfunction

    task automatic random_phase(int count, int noise_pct);
        pair_t p;
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            burst--;
            p = ($urandom_range(0, 99) < noise_pct) ? noise_pair() : touching_pair();
            send_pair(p);
        end
        drain();
    endtask

    initial
    begin
        pair_t p;
        board = new();
        hold_receiver = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0;
        first_x = '0; first_y = '0; first_vx = '0; first_vy = '0;
        second_x = '0; second_y = '0; second_vx = '0; second_vy = '0;
        center_distance = '0; offset_x = '0; offset_y = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset defaults: zero distance, extremes, a head-on
        // collision in each overlap band, a diagonal collision and a miss.
        p = '{0, 0, 100, 100, 0, 0, -100, -100, 31'd0, 0, 0};
        send_pair(p);
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_pair(p);
        p = '{-1, -1, -1, -1, -1, -1, -1, -1, 31'd1, 32'sh8000_0000, 32'sh7FFF_FFFF};
        send_pair(p);
        for (int band = 0; band < 4; band++)
        begin
            int dd;
            dd = (band == 0) ? 1100000 : (band == 1) ? 800000 : (band == 2) ? 400000 : 200000;
            p = '{0, 0, 65536, 0, dd, 0, -65536, 0, dd, dd, 0};
            send_pair(p);
        end
        p = '{0, 0, 600000, 600000, 900000, 900000, -600000, -600000,
              31'd1272792, 900000, 900000};
        send_pair(p);
        p = '{0, 0, -65536, 0, 1310720, 0, 65536, 0, 31'd1310720, 1310720, 0};
        send_pair(p);
        p = '{0, 0, 200000, 0, 0, 1310720, 0, 0, 31'd1310720, 0, 1310720};
        send_pair(p);
        p = '{0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, 32'sh8000_0000,
              32'sh8000_0000, 31'd2, 1, 1};
        send_pair(p);
        drain();

        // Random phases under several register settings, extremes included.
        random_phase(100, 20);

        write_register(bpcr_pkg::REG_RESTITUTION, 32'd65535);
        write_register(bpcr_pkg::REG_MAX_SPEED, 32'd0);
        write_register(bpcr_pkg::REG_BOOST_SCALE, 32'h7FFF_FFFF);
        write_register(bpcr_pkg::REG_BALL_RADIUS, 32'h7FFF_FFFF);
        random_phase(80, 30);

        write_register(bpcr_pkg::REG_RESTITUTION, 32'd0);
        write_register(bpcr_pkg::REG_MAX_SPEED, 32'h7FFF_FFFF);
        write_register(bpcr_pkg::REG_BOOST_SCALE, 32'd0);
        write_register(bpcr_pkg::REG_BALL_RADIUS, 32'd0);
        random_phase(60, 30);

        write_register(bpcr_pkg::REG_RESTITUTION, $urandom_range(0, 65535));
        write_register(bpcr_pkg::REG_MAX_SPEED, $urandom_range(0, 300000));
        write_register(bpcr_pkg::REG_BOOST_SCALE, $urandom());
        write_register(bpcr_pkg::REG_BALL_RADIUS, 32'd655360);

        // Long receiver hold-off while the sender keeps offering items, so the
        // pipeline fills and in_ready drops.
        fork
            begin
                hold_receiver = 1'b1;
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            begin
                for (int i = 0; i < 100; i++)
                    send_pair(touching_pair());
                in_valid <= 1'b0;
                @(posedge clk);
            end
        join
        drain();

        write_register(bpcr_pkg::REG_RESTITUTION, 32'd58982);
        write_register(bpcr_pkg::REG_MAX_SPEED, 32'd131072);
        write_register(bpcr_pkg::REG_BOOST_SCALE, 32'd524288);
        write_register(bpcr_pkg::REG_BALL_RADIUS, 32'd655360);
        random_phase(100, 15);

        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/bpcr_pkg.sv
hdl/bpcr_div.sv
hdl/ball_pair_collision_response.sv
hdl/bpcr_checker.sv
test/tb_ball_pair_collision_response.sv
